[rtl/core/rtbb_pkg.sv]
// Shared types, codes and helpers for the real-time bandwidth budget block.
// No dependencies; every other file in rtl/core except rtbb_ram refers to this package.
package rtbb_pkg;

  // Fixed field widths.
  localparam int BW_W     = 32;
  localparam int RATIO_W  = 16;
  localparam int TS_W     = 64;
  localparam int TYPE_W   = 3;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Default sizing for the top-level parameters.
  localparam int DEF_TYPE_COUNT = 4;
  localparam int DEF_LOG_DEPTH  = 8;

  // Number of client types that own a weight register.
  localparam int RATIO_REGS = 4;

  localparam logic [RATIO_W-1:0] THOUSAND = 16'd1000;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AVAIL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RATIO = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_QUERY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SET   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE_SHARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_3      = 3'd5;

  typedef logic [RATIO_REGS-1:0][RATIO_W-1:0] ratio_bank_t;

  // One entry of the availability log.
  typedef struct packed {
    logic [TS_W-1:0] stamp;
    logic [BW_W-1:0] value;
  } log_entry_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Weight of a client type; types without a register weigh one thousand.
  function automatic logic [RATIO_W-1:0] ratio_of(input ratio_bank_t regs,
                                                  input logic [TYPE_W-1:0] t);
    logic [RATIO_W-1:0] r;
    r = THOUSAND;
    if (t < TYPE_W'(RATIO_REGS)) begin
      r = regs[t[1:0]];
    end
    return r;
  endfunction

endpackage

[rtl/core/rtbb_in_if.sv]
// Input channel of the bandwidth budget block: valid/ready plus request fields.
// Depends on rtbb_pkg for field widths.
interface rtbb_in_if;
  logic                         valid;
  logic                         ready;
  logic [rtbb_pkg::KIND_W-1:0]  kind;
  logic [rtbb_pkg::TYPE_W-1:0]  type_index;
  logic [rtbb_pkg::BW_W-1:0]    bandwidth;
  logic [rtbb_pkg::TS_W-1:0]    timestamp;

  modport source (output valid, kind, type_index, bandwidth, timestamp, input ready);
  modport sink   (input valid, kind, type_index, bandwidth, timestamp, output ready);
endinterface

[rtl/core/rtbb_out_if.sv]
// Result channel of the bandwidth budget block: valid/ready plus result fields.
// Depends on rtbb_pkg for field widths.
interface rtbb_out_if;
  logic                          valid;
  logic                          ready;
  logic [rtbb_pkg::STATUS_W-1:0] status;
  logic [rtbb_pkg::BW_W-1:0]     remaining;
  logic [rtbb_pkg::RATIO_W-1:0]  ratio_out;
  logic                          logged;

  modport source (output valid, status, remaining, ratio_out, logged, input ready);
  modport sink   (input valid, status, remaining, ratio_out, logged, output ready);
endinterface

[rtl/core/realtime_bandwidth_budget_top.sv]
// Top level of the real-time bandwidth budget block.
// Depends on rtbb_pkg, rtbb_in_if, rtbb_out_if, rtbb_div and rtbb_ram.
//
// Usage:
//   Requests arrive on in_ch (valid/ready); each request produces exactly one
//   result item on out_ch (valid/ready). Registers are written through
//   cfg_we/cfg_index/cfg_data, by the user only while the block is idle, which
//   the block itself does not enforce: 0 total bandwidth, 1 usable share, 2..5
//   per-type weights. Other indexes are ignored. A set item stores a claim; an
//   availability query subtracts every other type's weighted claim from the
//   usable total and scales the remainder by the queried type's weight; a
//   ratio query returns a type's weight. Changed availability values are
//   written with their timestamp to a ring log.
//   Set, ratio and invalid items go from the idle state to ST_FIN, and their
//   result is loaded into the output register from there. In a valid
//   availability query each weighted claim and the two scalings run through
//   one shared multiplier and one divider retiring two quotient bits per
//   cycle while it is busy. One request is in work at a time; in_ch is ready
//   whenever the sequencer is idle, which it enters as a result is loaded,
//   so a new request is taken only after the last result is loaded.
// Reset (synchronous, active high) clears claims, total bandwidth, log valid
//   bits and the log pointer and sets the share and weights to 1000. A stalled
//   receiver holds the result in the output register; the next request may be
//   accepted meanwhile, and its result waits until the output register frees.
module realtime_bandwidth_budget_top #(
  parameter int TYPE_COUNT = rtbb_pkg::DEF_TYPE_COUNT,
  parameter int LOG_DEPTH  = rtbb_pkg::DEF_LOG_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  rtbb_in_if.sink                        in_ch,
  rtbb_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rtbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtbb_pkg::BW_W-1:0]      cfg_data
);

  localparam int IDX_W  = $clog2(TYPE_COUNT + 1);
  localparam int CIDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int LOG_W  = $clog2(LOG_DEPTH);
  localparam int ENTRY_W = $bits(rtbb_pkg::log_entry_t);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_CLAIM_MUL = 9'b000000010,
    ST_CLAIM_DIV = 9'b000000100,
    ST_TOTAL_MUL = 9'b000001000,
    ST_TOTAL_DIV = 9'b000010000,
    ST_SCALE_MUL = 9'b000100000,
    ST_SCALE_DIV = 9'b001000000,
    ST_LOG_CHK   = 9'b010000000,
    ST_FIN       = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [rtbb_pkg::BW_W-1:0]    total_bw;
  logic [rtbb_pkg::RATIO_W-1:0] usable_share;
  rtbb_pkg::ratio_bank_t        ratio_reg;

  // Claim table and captured request.
  logic [rtbb_pkg::BW_W-1:0]   claim [TYPE_COUNT];
  logic [rtbb_pkg::TYPE_W-1:0] type_q;
  logic [rtbb_pkg::TS_W-1:0]   stamp_q;

  // Sequencer datapath.
  logic [IDX_W-1:0]          idx;
  logic [rtbb_pkg::BW_W-1:0] used;
  logic [rtbb_pkg::BW_W-1:0] diff;

  // Result under construction and output register.
  logic [rtbb_pkg::STATUS_W-1:0] res_status;
  logic [rtbb_pkg::BW_W-1:0]     res_avail;
  logic [rtbb_pkg::RATIO_W-1:0]  res_ratio;
  logic                          res_logged;
  logic                          out_valid;
  logic [rtbb_pkg::STATUS_W-1:0] out_status;
  logic [rtbb_pkg::BW_W-1:0]     out_avail;
  logic [rtbb_pkg::RATIO_W-1:0]  out_ratio;
  logic                          out_logged;

  // Log bookkeeping.
  logic [LOG_W-1:0]        log_slot;
  logic [LOG_W-1:0]        log_prev;
  logic [LOG_DEPTH-1:0]    log_valid;
  logic                    log_we;
  rtbb_pkg::log_entry_t    log_wentry;
  logic [ENTRY_W-1:0]      log_rdata;
  rtbb_pkg::log_entry_t    log_rentry;
  logic [rtbb_pkg::BW_W-1:0] prev_value;

  // Shared multiplier and divider.
  logic [rtbb_pkg::BW_W-1:0]    mul_a;
  logic [rtbb_pkg::BW_W-1:0]    mul_b;
  logic [rtbb_pkg::BW_W-1:0]    mul_prod;
  logic                         div_start;
  logic [rtbb_pkg::RATIO_W-1:0] div_den;
  logic [rtbb_pkg::BW_W-1:0]    div_quo;
  rtbb_pkg::div_stat_t          div_stat;

  logic in_fire;
  logic type_ok;
  logic claim_active;
  logic out_free;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == ST_IDLE);
  assign type_ok      = ({1'b0, in_ch.type_index} < 4'(TYPE_COUNT));
  assign claim_active = (idx != IDX_W'(TYPE_COUNT)) && (4'(idx) != {1'b0, type_q});
  assign out_free     = !out_valid || out_ch.ready;

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_a     = claim[idx[CIDX_W-1:0]];
    mul_b     = 32'(rtbb_pkg::THOUSAND);
    div_den   = rtbb_pkg::ratio_of(ratio_reg, 3'(idx));
    div_start = 1'b0;
    case (state)
      ST_CLAIM_MUL: begin
        div_start = claim_active;
      end
      ST_TOTAL_MUL: begin
        mul_a     = total_bw;
        mul_b     = 32'(usable_share);
        div_den   = rtbb_pkg::THOUSAND;
        div_start = 1'b1;
      end
      ST_SCALE_MUL: begin
        mul_a     = diff;
        mul_b     = 32'(rtbb_pkg::ratio_of(ratio_reg, type_q));
        div_den   = rtbb_pkg::THOUSAND;
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Only the low word of the product is kept; the arithmetic is modulo 2^32.
  assign mul_prod = mul_a * mul_b;

  rtbb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_prod),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Log ring: read the previous slot, write the current one.
  assign log_prev   = (log_slot == '0) ? LOG_W'(LOG_DEPTH - 1) : log_slot - 1'b1;
  assign log_rentry = rtbb_pkg::log_entry_t'(log_rdata);
  assign prev_value = log_valid[log_prev] ? log_rentry.value : '0;
  assign log_we     = (state == ST_LOG_CHK) && (prev_value != res_avail);
  assign log_wentry = '{stamp: stamp_q, value: res_avail};

  rtbb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_slot),
    .wdata (log_wentry),
    .raddr (log_prev),
    .rdata (log_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bw     <= '0;
      usable_share <= rtbb_pkg::THOUSAND;
      for (int i = 0; i < rtbb_pkg::RATIO_REGS; i++) begin
        ratio_reg[i] <= rtbb_pkg::THOUSAND;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rtbb_pkg::REG_TOTAL_BW:     total_bw     <= cfg_data;
        rtbb_pkg::REG_USABLE_SHARE: usable_share <= cfg_data[rtbb_pkg::RATIO_W-1:0];
        rtbb_pkg::REG_RATIO_0:      ratio_reg[0] <= cfg_data[rtbb_pkg::RATIO_W-1:0];
        rtbb_pkg::REG_RATIO_1:      ratio_reg[1] <= cfg_data[rtbb_pkg::RATIO_W-1:0];
        rtbb_pkg::REG_RATIO_2:      ratio_reg[2] <= cfg_data[rtbb_pkg::RATIO_W-1:0];
        rtbb_pkg::REG_RATIO_3:      ratio_reg[3] <= cfg_data[rtbb_pkg::RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      log_slot  <= '0;
      log_valid <= '0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
        claim[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            type_q     <= in_ch.type_index;
            stamp_q    <= in_ch.timestamp;
            res_status <= rtbb_pkg::STATUS_OK;
            res_avail  <= '0;
            res_ratio  <= '0;
            res_logged <= 1'b0;
            idx        <= '0;
            used       <= '0;
            state      <= ST_FIN;
            case (in_ch.kind)
              rtbb_pkg::KIND_SET: begin
                if (type_ok) begin
                  claim[in_ch.type_index[CIDX_W-1:0]] <= in_ch.bandwidth;
                end else begin
                  res_status <= rtbb_pkg::STATUS_BAD_SET;
                end
              end
              rtbb_pkg::KIND_AVAIL: begin
                if (type_ok) begin
                  state <= ST_CLAIM_MUL;
                end else begin
                  res_status <= rtbb_pkg::STATUS_BAD_QUERY;
                end
              end
              rtbb_pkg::KIND_RATIO: begin
                res_ratio <= type_ok ? rtbb_pkg::ratio_of(ratio_reg, in_ch.type_index)
                                     : rtbb_pkg::THOUSAND;
              end
              default: begin
              end
            endcase
          end
        end
        // Walk the other types; the divider is started here when one applies.
        ST_CLAIM_MUL: begin
          if (idx == IDX_W'(TYPE_COUNT)) begin
            state <= ST_TOTAL_MUL;
          end else if (claim_active) begin
            state <= ST_CLAIM_DIV;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_CLAIM_DIV: begin
          if (div_stat.done) begin
            used  <= used + div_quo;
            idx   <= idx + 1'b1;
            state <= ST_CLAIM_MUL;
          end
        end
        ST_TOTAL_MUL: begin
          state <= ST_TOTAL_DIV;
        end
        ST_TOTAL_DIV: begin
          if (div_stat.done) begin
            diff  <= div_quo - used;
            state <= ST_SCALE_MUL;
          end
        end
        ST_SCALE_MUL: begin
          state <= ST_SCALE_DIV;
        end
        ST_SCALE_DIV: begin
          if (div_stat.done) begin
            res_avail <= div_quo;
            state     <= ST_LOG_CHK;
          end
        end
        // Log only when the value moved since the last entry.
        ST_LOG_CHK: begin
          if (log_we) begin
            log_valid[log_slot] <= 1'b1;
            log_slot   <= (log_slot == LOG_W'(LOG_DEPTH - 1)) ? '0 : log_slot + 1'b1;
            res_logged <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_status <= res_status;
      out_avail  <= res_avail;
      out_ratio  <= res_ratio;
      out_logged <= res_logged;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.remaining = out_avail;
  assign out_ch.ratio_out = out_ratio;
  assign out_ch.logged    = out_logged;

  // The divider reports completion only while the sequencer waits on it.
  a_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_CLAIM_DIV || state == ST_TOTAL_DIV ||
                       state == ST_SCALE_DIV))
    else $error("divider finished outside a divide state");

  // A new request is never taken while the divider is still working.
  a_idle_div_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  // A log write always advances the ring pointer.
  a_log_advance: assert property (@(posedge clk) disable iff (rst)
    log_we |=> (log_slot != $past(log_slot)))
    else $error("log pointer did not advance");

  // Only a successful query can report a log entry.
  a_logged_ok: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.logged) |-> (out_ch.status == rtbb_pkg::STATUS_OK))
    else $error("log flag on a failed result");

endmodule

[rtl/core/rtbb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module rtbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rtbb_div.sv]
// Iterative 32-by-16 unsigned divider, two quotient bits per cycle.
// Depends on rtbb_pkg. A zero divisor gives an all-ones quotient.
module rtbb_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rtbb_pkg::BW_W-1:0]    num,
  input  logic [rtbb_pkg::RATIO_W-1:0] den,
  output logic [rtbb_pkg::BW_W-1:0]    quo,
  output rtbb_pkg::div_stat_t          stat
);

  localparam int BITS_PER_STEP = 2;
  localparam int STEPS = rtbb_pkg::BW_W / BITS_PER_STEP;
  localparam int CNT_W = $clog2(STEPS);

  logic [rtbb_pkg::RATIO_W-1:0] rem;
  logic [rtbb_pkg::RATIO_W-1:0] den_q;
  logic [rtbb_pkg::BW_W-1:0]    q;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         done;
  logic [rtbb_pkg::RATIO_W-1:0] rem_next;
  logic [rtbb_pkg::BW_W-1:0]    q_next;

  // Two restoring steps: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [rtbb_pkg::RATIO_W:0] trial;
    rem_next = rem;
    q_next   = q;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      trial  = {rem_next, q_next[rtbb_pkg::BW_W-1]};
      q_next = {q_next[rtbb_pkg::BW_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        q_next[0] = 1'b1;
      end
      rem_next = trial[rtbb_pkg::RATIO_W-1:0];
    end
  end

  // Control: load on start, count steps, pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      q     <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= rem_next;
      q   <= q_next;
    end
  end

  assign quo       = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
